[sv/fractional_n_pll_divider_calc_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef FRACTIONAL_N_PLL_DIVIDER_CALC_TOP_ASSERT_SVH
`define FRACTIONAL_N_PLL_DIVIDER_CALC_TOP_ASSERT_SVH

// same-cycle implication
`define FNPLL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FNPLL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/fnpll_pkg.sv]
package fnpll_pkg;

	localparam int FREQ_W    = 22;
	localparam int XTAL_W    = 16;
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 2;
	localparam int R_W       = 2;
	localparam int A_W       = FREQ_W + R_W;
	localparam int NUM_W     = A_W + 2;
	localparam int FRAC_BITS = 17;
	localparam int QUO_W     = NUM_W + FRAC_BITS;
	localparam int CNT_W     = 5;
	localparam int N_W       = 9;
	localparam int F_W       = 19;

	localparam int MAX_REF_TRIES = 3;

	localparam logic [N_W-1:0] N_ERR = 9'd6;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CRYSTAL = 2'd0,
		REG_VARIANT = 2'd1,
		REG_WINDOW  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

[sv/fnpll_if.sv]
interface fnpll_req_if;
	import fnpll_pkg::*;

	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] frequency_khz;

	modport source (output valid, output frequency_khz, input ready);
	modport sink   (input valid, input frequency_khz, output ready);
endinterface

interface fnpll_rsp_if;
	import fnpll_pkg::*;

	logic                valid;
	logic                ready;
	logic [N_W-1:0]      n_int;
	logic signed [F_W-1:0] f_frac;
	logic [R_W-1:0]      ref_div;
	logic                vco_div_by_four;
	logic                fraction_zeroed;
	logic                pll_error;

	modport source (
		output valid, output n_int, output f_frac, output ref_div,
		output vco_div_by_four, output fraction_zeroed, output pll_error,
		input ready
	);
	modport sink (
		input valid, input n_int, input f_frac, input ref_div,
		input vco_div_by_four, input fraction_zeroed, input pll_error,
		output ready
	);
endinterface

[sv/fnpll_div.sv]
// Restoring divider, one quotient bit per step.
module fnpll_div
	import fnpll_pkg::*;
(
	input  logic              clk,
	input  div_ctrl_t         ctrl,
	input  logic [NUM_W-1:0]  numer,
	input  logic [XTAL_W-1:0] denom,
	output logic [QUO_W-1:0]  quo
);

	logic [NUM_W-1:0]  num_q;
	logic [XTAL_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [XTAL_W:0]   trial;
	logic [XTAL_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, denom};
	assign diff  = trial - {1'b0, denom};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q <= numer;
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctrl.step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? diff[XTAL_W-1:0] : trial[XTAL_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quo = quo_q;

endmodule

[sv/fractional_n_pll_divider_calc_top.sv]
// Fractional-N divider calculator. A transaction on req carries a tuning
// frequency in kHz; one transaction on rsp returns N (offset by -32), the signed
// fraction F in 1/262144 units, the reference divider R, the VCO divider choice
// and the zeroed/error flags. Configuration (crystal kHz, chip variant, fraction
// window) is written through cfg_we/cfg_index/cfg_data while no request is in
// flight. All division work runs through one shared restoring divider, one
// quotient bit per cycle: each R try loads the divider, shifts in 26 integer
// quotient bits and checks them; the fraction adds 17 more quotient bits, then
// the result is finished. req is not ready while a request is in progress; a
// finished result can wait in the output register while the next request is
// being worked on.
module fractional_n_pll_divider_calc_top
	import fnpll_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	fnpll_req_if.sink            req,
	fnpll_rsp_if.source          rsp
);

	localparam logic [FREQ_W-1:0] VCO4_BELOW_BASE    = 22'd1100000;
	localparam logic [FREQ_W-1:0] VCO4_BELOW_VARIANT = 22'd1165000;
	localparam logic [XTAL_W-1:0] XTAL_RESET         = 16'd10111;
	localparam logic [XTAL_W-1:0] XTAL_DOUBLE        = 16'd20000;
	localparam int                N_MIN_TOTAL        = 38;
	localparam logic [NUM_W-1:0]  Q_MIN              = NUM_W'(2 * N_MIN_TOTAL - 1);
	localparam logic [N_W-1:0]    N_OFFSET           = 9'd32;
	localparam int                FRAC_ONE           = 262144;
	localparam int                FRAC_LIMIT         = FRAC_ONE / 2 - 1638;
	localparam int                FRAC_SMALL         = 3277;
	localparam logic signed [F_W-1:0] F_LIM_POS   = F_W'(FRAC_LIMIT);
	localparam logic signed [F_W-1:0] F_LIM_NEG   = F_W'(-FRAC_LIMIT);
	localparam logic signed [F_W-1:0] F_SMALL_POS = F_W'(FRAC_SMALL);
	localparam logic signed [F_W-1:0] F_SMALL_NEG = F_W'(-FRAC_SMALL);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_DIV  = 6'b000100,
		S_CHK  = 6'b001000,
		S_FRAC = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t             state_q;
	logic [XTAL_W-1:0]  xtal_q;
	logic               variant_q;
	logic               window_q;
	logic [FREQ_W-1:0]  freq_q;
	logic               vco4_q;
	logic [1:0]         shift_q;
	logic [R_W-1:0]     try_q;
	logic [R_W-1:0]     r_q;
	logic               err_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               rsp_valid_q;
	logic [N_W-1:0]     n_q;
	logic signed [F_W-1:0] f_q;
	logic [R_W-1:0]     refdiv_q;
	logic               vco4o_q;
	logic               zero_q;
	logic               perr_q;

	div_ctrl_t          div_ctrl;
	logic [NUM_W-1:0]   div_numer;
	logic [QUO_W-1:0]   quo;

	logic               req_acc;
	logic               vco4_in;
	logic               xtal_dbl;
	logic [R_W-1:0]     r_cur;
	logic [A_W-1:0]     a_val;
	logic               try_ok;
	logic               out_free;
	logic [N_W:0]       q_inc;
	logic [N_W-1:0]     n_calc;
	logic signed [F_W-1:0] f_raw;
	logic signed [F_W-1:0] f_clamp;
	logic               f_small;
	logic [N_W-1:0]     n_res;
	logic signed [F_W-1:0] f_res;
	logic               zero_res;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_q    <= XTAL_RESET;
			variant_q <= 1'b0;
			window_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CRYSTAL: xtal_q    <= cfg_data[XTAL_W-1:0];
				REG_VARIANT: variant_q <= cfg_data[0];
				REG_WINDOW:  window_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	assign vco4_in  = req.frequency_khz < (variant_q ? VCO4_BELOW_VARIANT : VCO4_BELOW_BASE);
	assign xtal_dbl = xtal_q >= XTAL_DOUBLE;

	// R for this try and A = f * R, dividend = A * Vdiv / (2K) * 2
	assign r_cur     = (variant_q && vco4_q) ? R_W'(2) : try_q;
	assign a_val     = (r_cur[0] ? A_W'(freq_q) : '0) + (r_cur[1] ? {1'b0, freq_q, 1'b0} : '0);
	assign div_numer = {2'b00, a_val} << shift_q;

	assign try_ok   = (xtal_q != '0) && (quo[NUM_W-1:0] >= Q_MIN);
	assign out_free = !rsp_valid_q || rsp.ready;

	assign div_ctrl.load = (state_q == S_LOAD);
	assign div_ctrl.step = (state_q == S_DIV) || (state_q == S_FRAC);

	fnpll_div u_div (
		.clk   (clk),
		.ctrl  (div_ctrl),
		.numer (div_numer),
		.denom (xtal_q),
		.quo   (quo)
	);

	// M = (q + 1) / 2; F = low fraction bits with the rounding carry as sign
	assign q_inc  = quo[FRAC_BITS +: N_W+1] + (N_W+1)'(1);
	assign n_calc = q_inc[N_W:1] - N_OFFSET;
	assign f_raw  = {quo[FRAC_BITS], quo[FRAC_BITS:0]};

	always_comb begin
		f_clamp = f_raw;
		if (f_raw > F_LIM_POS) begin
			f_clamp = F_LIM_POS;
		end else if (f_raw < F_LIM_NEG) begin
			f_clamp = F_LIM_NEG;
		end
		f_small = ((f_clamp > 0) && (f_clamp < F_SMALL_POS))
			|| ((f_clamp < 0) && (f_clamp > F_SMALL_NEG));
		if (err_q) begin
			n_res    = N_ERR;
			f_res    = '0;
			zero_res = 1'b0;
		end else if (window_q) begin
			n_res    = n_calc;
			f_res    = f_small ? '0 : f_clamp;
			zero_res = f_small;
		end else begin
			n_res    = n_calc;
			f_res    = f_raw;
			zero_res = 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			try_q   <= '0;
			err_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						try_q   <= R_W'(1);
						err_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q   <= CNT_W'(NUM_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_CHK;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_CHK: begin
					if (try_ok) begin
						cnt_q   <= CNT_W'(FRAC_BITS - 1);
						state_q <= S_FRAC;
					end else if (try_q == R_W'(MAX_REF_TRIES)) begin
						err_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						try_q   <= try_q + R_W'(1);
						state_q <= S_LOAD;
					end
				end
				S_FRAC: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-request payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			freq_q  <= req.frequency_khz;
			vco4_q  <= vco4_in;
			shift_q <= vco4_in ? (xtal_dbl ? 2'd1 : 2'd2) : (xtal_dbl ? 2'd0 : 2'd1);
		end
		if (state_q == S_LOAD) begin
			r_q <= r_cur;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			n_q      <= n_res;
			f_q      <= f_res;
			refdiv_q <= r_q;
			vco4o_q  <= vco4_q;
			zero_q   <= zero_res;
			perr_q   <= err_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.n_int           = n_q;
	assign rsp.f_frac          = f_q;
	assign rsp.ref_div         = refdiv_q;
	assign rsp.vco_div_by_four = vco4o_q;
	assign rsp.fraction_zeroed = zero_q;
	assign rsp.pll_error       = perr_q;

endmodule

[sv/fnpll_chk.sv]
`include "fractional_n_pll_divider_calc_top_assert.svh"

module fnpll_chk
	import fnpll_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [N_W-1:0]        n_int,
	input logic signed [F_W-1:0] f_frac,
	input logic [R_W-1:0]        ref_div,
	input logic                  fraction_zeroed,
	input logic                  pll_error
);

	// one request at a time
	`FNPLL_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "req ready while busy")

	`FNPLL_ASSERT_NOW(a_err_result, rsp_valid && pll_error, (n_int == N_ERR) && (f_frac == '0) && !fraction_zeroed, "bad error result")

	`FNPLL_ASSERT_NOW(a_zeroed_frac, rsp_valid && fraction_zeroed, (f_frac == '0) && (ref_div != '0), "zeroed flag with nonzero fraction")

	`FNPLL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(n_int) && $stable(f_frac) && $stable(ref_div), "rsp dropped or changed while stalled")

endmodule

bind fractional_n_pll_divider_calc_top fnpll_chk u_fnpll_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.n_int           (rsp.n_int),
	.f_frac          (rsp.f_frac),
	.ref_div         (rsp.ref_div),
	.fraction_zeroed (rsp.fraction_zeroed),
	.pll_error       (rsp.pll_error)
);

[tb/fractional_n_pll_divider_calc_top_tb.sv]
`timescale 1ns / 1ps

module fractional_n_pll_divider_calc_top_tb;
	import fnpll_pkg::*;

	localparam longint FRAC_UNIT     = 262144;
	localparam longint FRAC_CLAMP    = FRAC_UNIT / 2 - 1638;
	localparam longint FRAC_DEADBAND = 3277;
	localparam longint N_FLOOR       = 38;
	localparam longint N_BIAS        = 32;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int DIR_ROWS      = 23;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 128;
	localparam int CALM_LO       = 700;
	localparam int CALM_HI       = 900;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 120;
	localparam int WATCHDOG_MAX  = 20000;

	typedef struct packed {
		logic [N_W-1:0]        n_int;
		logic signed [F_W-1:0] f_frac;
		logic [R_W-1:0]        ref_div;
		logic                  vco_div_by_four;
		logic                  fraction_zeroed;
		logic                  pll_error;
	} divider_word_t;

	typedef struct {
		bit            given;
		divider_word_t word;
	} typed_entry_t;

	typedef struct {
		logic [XTAL_W-1:0] xt;
		bit                vs;
		bit                win;
		logic [FREQ_W-1:0] freq;
		bit                given;
		divider_word_t     word;
	} dir_row_t;

	localparam divider_word_t NO_WORD = '0;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	fnpll_req_if req_ch ();
	fnpll_rsp_if rsp_ch ();

	fractional_n_pll_divider_calc_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic [XTAL_W-1:0] xtal_khz = 16'd10111;
	bit variant_sel = 1'b0;
	bit window_on = 1'b1;

	divider_word_t expected_words [$];
	typed_entry_t typed_q [$];
	int issued = 0;
	int results_seen = 0;
	int errors = 0;
	int idle_cycles = 0;

	// crystal, variant, window, frequency, typed, expected
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{16'd10111, 1'b0, 1'b1, 22'd0,       1'b1, '{9'd6, 19'sd0, 2'd3, 1'b1, 1'b0, 1'b1}},
		'{16'd10111, 1'b0, 1'b1, 22'd950000,  1'b0, NO_WORD},
		'{16'd10111, 1'b0, 1'b1, 22'd2150000, 1'b0, NO_WORD},
		'{16'd10111, 1'b0, 1'b1, 22'd1099999, 1'b0, NO_WORD},
		'{16'd10111, 1'b0, 1'b1, 22'd1100000, 1'b0, NO_WORD},
		'{16'd10111, 1'b0, 1'b1, 22'd4194303, 1'b0, NO_WORD},
		'{16'd10000, 1'b0, 1'b1, 22'd1200100, 1'b1, '{9'd88, 19'sd0, 2'd1, 1'b0, 1'b1, 1'b0}},
		'{16'd10000, 1'b0, 1'b1, 22'd1199900, 1'b1, '{9'd88, 19'sd0, 2'd1, 1'b0, 1'b1, 1'b0}},
		'{16'd10000, 1'b0, 1'b1, 22'd1205000, 1'b1,
			'{9'd89, -19'sd129434, 2'd1, 1'b0, 1'b0, 1'b0}},
		'{16'd10000, 1'b0, 1'b1, 22'd1204990, 1'b1,
			'{9'd88, 19'sd129434, 2'd1, 1'b0, 1'b0, 1'b0}},
		'{16'd10000, 1'b0, 1'b0, 22'd1205000, 1'b1,
			'{9'd89, -19'sd131072, 2'd1, 1'b0, 1'b0, 1'b0}},
		'{16'd10000, 1'b0, 1'b0, 22'd1200100, 1'b1, '{9'd88, 19'sd2621, 2'd1, 1'b0, 1'b0, 1'b0}},
		'{16'd0,     1'b0, 1'b1, 22'd2150000, 1'b1, '{9'd6, 19'sd0, 2'd3, 1'b0, 1'b0, 1'b1}},
		'{16'd0,     1'b1, 1'b1, 22'd950000,  1'b1, '{9'd6, 19'sd0, 2'd2, 1'b1, 1'b0, 1'b1}},
		'{16'd65535, 1'b0, 1'b1, 22'd950000,  1'b0, NO_WORD},
		'{16'd65535, 1'b0, 1'b1, 22'd1100000, 1'b0, NO_WORD},
		'{16'd65535, 1'b1, 1'b1, 22'd1164999, 1'b0, NO_WORD},
		'{16'd65535, 1'b1, 1'b1, 22'd1165000, 1'b0, NO_WORD},
		'{16'd20000, 1'b1, 1'b0, 22'd1100000, 1'b0, NO_WORD},
		'{16'd19999, 1'b1, 1'b1, 22'd2150000, 1'b0, NO_WORD},
		'{16'd1,     1'b0, 1'b1, 22'd4194303, 1'b0, NO_WORD},
		'{16'd60000, 1'b0, 1'b0, 22'd950000,  1'b0, NO_WORD},
		'{16'd60000, 1'b1, 1'b1, 22'd2150000, 1'b0, NO_WORD}
	};

	function automatic divider_word_t calc_divider_word(input logic [FREQ_W-1:0] freq);
		longint unsigned fhz, k, thresh, vdiv, r, m, q, num, den, nm;
		longint f;
		bit found;
		divider_word_t w;
		fhz = 64'(freq) * 64'd1000;
		k = (xtal_khz < 16'd20000) ? 1 : 2;
		thresh = variant_sel ? 1165000 : 1100000;
		vdiv = (64'(freq) >= thresh) ? 2 : 4;
		r = 1;
		m = 0;
		f = 0;
		found = 1'b0;
		for (int t = 1; t <= MAX_REF_TRIES && t <= 3 && !found; t++) begin
			r = 64'(t);
			if (variant_sel && vdiv == 4)
				r = 2;
			if (xtal_khz != 0) begin
				q = ((fhz / 100) * vdiv * r) / (64'(xtal_khz) * k * 2);
				m = (q + 5) / 10;
				found = (m >= N_FLOOR);
			end
		end
		w = '0;
		w.n_int = N_ERR;
		w.ref_div = r[R_W-1:0];
		w.vco_div_by_four = (vdiv == 4);
		w.pll_error = !found;
		if (found) begin
			num = fhz * r * vdiv * FRAC_UNIT;
			den = 64'(xtal_khz) * 1000 * k * 2;
			f = longint'(num / den) - longint'(m * FRAC_UNIT);
			if (window_on) begin
				if (f > FRAC_CLAMP)
					f = FRAC_CLAMP;
				if (f < -FRAC_CLAMP)
					f = -FRAC_CLAMP;
				if ((f > 0 && f < FRAC_DEADBAND) || (f < 0 && f > -FRAC_DEADBAND)) begin
					f = 0;
					w.fraction_zeroed = 1'b1;
				end
			end
			nm = m - N_BIAS;
			w.n_int = nm[N_W-1:0];
		end
		w.f_frac = f[F_W-1:0];
		return w;
	endfunction

	task automatic report_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic offer_frequency(input logic [FREQ_W-1:0] freq, input bit given,
			input divider_word_t word);
		typed_entry_t e;
		while ((issued < CALM_LO || issued >= CALM_HI) && $urandom_range(99) < 20) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		e.given = given;
		e.word = word;
		typed_q.push_back(e);
		req_ch.valid <= 1'b1;
		req_ch.frequency_khz <= freq;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		issued++;
	endtask

	// quiesce the request side and wait for every outstanding result
	task automatic settle();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_words.size() != 0);
	endtask

	task automatic set_config(input logic [XTAL_W-1:0] xt, input bit vs, input bit win);
		logic [15:0] pad;
		pad = 16'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= REG_CRYSTAL;
		cfg_data <= xt;
		@(posedge clk);
		cfg_index <= REG_VARIANT;
		cfg_data <= {pad[15:1], vs};
		@(posedge clk);
		cfg_index <= REG_WINDOW;
		cfg_data <= {pad[14:0], win};
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= ~pad;
		@(posedge clk);
		cfg_we <= 1'b0;
		xtal_khz = xt;
		variant_sel = vs;
		window_on = win;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (results_seen >= HOLD_AT && results_seen < HOLD_AT + 10) begin
				// long back-pressure so the block fills and stalls req
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ch.ready <= 1'b1;
				wait (results_seen >= HOLD_AT + 10);
			end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 20);
			end
		end
	end

	always @(posedge clk) begin
		typed_entry_t e;
		divider_word_t want;
		if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
			e = typed_q.pop_front();
			want = e.given ? e.word : calc_divider_word(req_ch.frequency_khz);
			expected_words.push_back(want);
		end
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual n_int %0d f_frac %0d", $time,
					rsp_ch.n_int, rsp_ch.f_frac);
			end else begin
				want = expected_words.pop_front();
				report_field("n_int", want.n_int, rsp_ch.n_int);
				report_field("f_frac", want.f_frac, rsp_ch.f_frac);
				report_field("ref_div", want.ref_div, rsp_ch.ref_div);
				report_field("vco_div_by_four", want.vco_div_by_four, rsp_ch.vco_div_by_four);
				report_field("fraction_zeroed", want.fraction_zeroed, rsp_ch.fraction_zeroed);
				report_field("pll_error", want.pll_error, rsp_ch.pll_error);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_MAX) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [XTAL_W-1:0] xt;
		logic [FREQ_W-1:0] freq;
		int pick;
		int near;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CRYSTAL;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.frequency_khz = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].xt != xtal_khz || dir_rows[i].vs != variant_sel ||
					dir_rows[i].win != window_on) begin
				settle();
				set_config(dir_rows[i].xt, dir_rows[i].vs, dir_rows[i].win);
			end
			offer_frequency(dir_rows[i].freq, dir_rows[i].given, dir_rows[i].word);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: xt = 16'd10000;
				1: xt = 16'd60000;
				2: xt = 16'd19999;
				3: xt = 16'd20000;
				4: xt = 16'd0;
				5: xt = 16'd1;
				6: xt = 16'd65535;
				default: xt = ph[0] ? 16'($urandom_range(10000, 60000)) : 16'($urandom);
			endcase
			settle();
			set_config(xt, ph[0], !ph[1]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					freq = FREQ_W'($urandom_range(950000, 2150000));
				end else if (pick < 90) begin
					near = (pick[0] ? 1100000 : 1165000) + $urandom_range(0, 16) - 8;
					freq = near[FREQ_W-1:0];
				end else begin
					freq = FREQ_W'($urandom_range(0, 4194303));
				end
				offer_frequency(freq, 1'b0, NO_WORD);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/fnpll_pkg.sv
sv/fnpll_if.sv
sv/fnpll_div.sv
sv/fractional_n_pll_divider_calc_top.sv
sv/fnpll_chk.sv
tb/fractional_n_pll_divider_calc_top_tb.sv
